[rtl/core/sau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sau_pkg - shared types and helpers of the scroll address unit
// Beat codes, result struct and the coarse X / coarse Y stepping functions.
// ----------------------------------------------------------------------------
package sau_pkg;

   // default parameter values
   localparam int LINE_WIDTH_DEF     = 256;
   localparam int NAMETABLE_BASE_DEF = 8192;

   // field widths
   localparam int ADDR_W  = 15;
   localparam int LINE_W  = 9;
   localparam int DOT_W   = 9;
   localparam int FETCH_W = 14;
   localparam int FINE_W  = 3;
   localparam int SHIFT_W = 3;

   // dot positions and lines with special updates
   localparam logic [DOT_W-1:0]  DOT_INC_Y    = 9'd256;
   localparam logic [DOT_W-1:0]  DOT_HORZ     = 9'd257;
   localparam logic [DOT_W-1:0]  DOT_VERT     = 9'd304;
   localparam logic [DOT_W-1:0]  DOT_LAST     = 9'd340;
   localparam logic [LINE_W-1:0] LINE_VISIBLE = 9'd240;
   localparam logic [LINE_W-1:0] LINE_PRE     = 9'd261;

   // copy masks
   localparam logic [ADDR_W-1:0] MASK_HORZ_KEEP = 15'h7BE0;
   localparam logic [ADDR_W-1:0] MASK_HORZ_COPY = 15'h041F;
   localparam logic [ADDR_W-1:0] MASK_VERT_KEEP = 15'h041F;
   localparam logic [ADDR_W-1:0] MASK_VERT_COPY = 15'h7BE0;

   localparam logic [FETCH_W-1:0] ATTR_BASE = 14'h23C0;
   localparam logic [4:0]         COARSE_Y_LAST_ROW = 5'd29;
   localparam logic [4:0]         COARSE_Y_MAX      = 5'd31;

   // item kinds
   typedef enum logic [2:0] {
      ACT_TICK      = 3'd0,
      ACT_LINE      = 3'd1,
      ACT_WRITE_V   = 3'd2,
      ACT_WRITE_T   = 3'd3,
      ACT_WRITE_FX  = 3'd4,
      ACT_CONTROL   = 3'd5
   } action_type;

   // configuration register indexes
   localparam logic CSR_BG_ENABLE  = 1'b0;
   localparam logic CSR_SPR_ENABLE = 1'b1;

   // one result beat
   typedef struct packed {
      logic [SHIFT_W-1:0] attr_shift;
      logic [FETCH_W-1:0] attr_addr;
      logic [FETCH_W-1:0] name_addr;
      logic               tile_fetch;
      logic [DOT_W-1:0]   dot_count;
      logic [ADDR_W-1:0]  tmp_addr;
      logic [ADDR_W-1:0]  cur_addr;
   } result_type;

   // coarse X step, wrapping into the neighbor nametable
   function automatic logic [ADDR_W-1:0] next_coarse_x(input logic [ADDR_W-1:0] v);
      logic [ADDR_W-1:0] r;
      r = v;
      if (v[4:0] == 5'h1F) begin
         r[4:0] = 5'd0;
         r[10]  = ~v[10];
      end else begin
         r = v + 15'd1;
      end
      return r;
   endfunction

   // fine Y / coarse Y step, wrapping into the vertical nametable at row 29
   function automatic logic [ADDR_W-1:0] next_coarse_y(input logic [ADDR_W-1:0] v);
      logic [ADDR_W-1:0] r;
      r = v;
      if (v[14:12] != 3'd7) begin
         r[14:12] = v[14:12] + 3'd1;
      end else begin
         r[14:12] = 3'd0;
         if (v[9:5] == COARSE_Y_LAST_ROW) begin
            r[9:5] = 5'd0;
            r[11]  = ~v[11];
         end else if (v[9:5] == COARSE_Y_MAX) begin
            r[9:5] = 5'd0;
         end else begin
            r[9:5] = v[9:5] + 5'd1;
         end
      end
      return r;
   endfunction

endpackage

[rtl/core/sau_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sau_state - scroll registers and their per-beat update
// Holds v, t, fine X, dot counter, column phase/cursor and the enables;
// computes the result of each accepted beat from the updated state.
// ----------------------------------------------------------------------------
module sau_state #(
   parameter int LINE_WIDTH     = sau_pkg::LINE_WIDTH_DEF,
   parameter int NAMETABLE_BASE = sau_pkg::NAMETABLE_BASE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic                        csr_index,
   input  logic                        csr_data,
   input  logic                        beat,
   input  logic [2:0]                  action,
   input  logic [sau_pkg::LINE_W-1:0]  scanline,
   input  logic [sau_pkg::ADDR_W-1:0]  value,
   output sau_pkg::result_type         result
);
   import sau_pkg::*;

   localparam int CURSOR_W = $clog2(LINE_WIDTH + 1);
   localparam logic [CURSOR_W-1:0] CURSOR_END = CURSOR_W'(LINE_WIDTH);
   localparam logic [FETCH_W-1:0]  NT_BASE    = FETCH_W'(NAMETABLE_BASE);

   logic                 bg_enable_ff, spr_enable_ff;
   logic [ADDR_W-1:0]    v_ff, v_in;
   logic [ADDR_W-1:0]    t_ff, t_in;
   logic [FINE_W-1:0]    fine_x_ff, fine_x_in;
   logic [DOT_W-1:0]     dot_ff, dot_in;
   logic [2:0]           phase_ff, phase_in;
   logic [CURSOR_W-1:0]  cursor_ff, cursor_in;
   logic                 fetch;
   logic                 active;
   logic                 in_line;
   action_type           act;

   assign act     = action_type'(action);
   assign active  = bg_enable_ff | spr_enable_ff;
   assign in_line = cursor_ff < CURSOR_END;

   // next state for one beat
   always_comb begin
      v_in      = v_ff;
      t_in      = t_ff;
      fine_x_in = fine_x_ff;
      dot_in    = dot_ff;
      phase_in  = phase_ff;
      cursor_in = cursor_ff;
      fetch     = 1'b0;
      case (act)
         ACT_TICK: begin
            // dot-position updates are mutually exclusive
            if (dot_ff == DOT_INC_Y && active && scanline < LINE_VISIBLE) begin
               v_in = next_coarse_y(v_ff);
            end else if (dot_ff == DOT_HORZ && active && scanline < LINE_VISIBLE) begin
               v_in = (v_ff & MASK_HORZ_KEEP) | (t_ff & MASK_HORZ_COPY);
            end else if (dot_ff == DOT_VERT && active && scanline == LINE_PRE) begin
               v_in = (v_ff & MASK_VERT_KEEP) | (t_ff & MASK_VERT_COPY);
            end else if (dot_ff == DOT_LAST && scanline == LINE_PRE && bg_enable_ff) begin
               v_in = next_coarse_y(v_ff);
            end
            // column stepping, fetch every eighth pixel
            if (in_line && bg_enable_ff) begin
               if (phase_ff == 3'd0) begin
                  v_in     = next_coarse_x(v_in);
                  fetch    = 1'b1;
                  phase_in = 3'd7;
               end else begin
                  phase_in = phase_ff - 3'd1;
               end
            end
            if (in_line) begin
               cursor_in = cursor_ff + CURSOR_W'(1);
            end
            dot_in = (dot_ff == DOT_LAST) ? '0 : dot_ff + 9'd1;
         end
         ACT_LINE: begin
            phase_in  = 3'd7 - fine_x_ff;
            cursor_in = '0;
            fetch     = 1'b1;
         end
         ACT_WRITE_V:  v_in      = value;
         ACT_WRITE_T:  t_in      = value;
         ACT_WRITE_FX: fine_x_in = value[FINE_W-1:0];
         ACT_CONTROL: begin
            t_in        = t_ff;
            t_in[11:10] = value[1:0];
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         t_ff      <= '0;
         fine_x_ff <= '0;
         dot_ff    <= '0;
         phase_ff  <= 3'd7;
         cursor_ff <= '0;
      end else if (beat) begin
         v_ff      <= v_in;
         t_ff      <= t_in;
         fine_x_ff <= fine_x_in;
         dot_ff    <= dot_in;
         phase_ff  <= phase_in;
         cursor_ff <= cursor_in;
      end
   end

   // enables
   always_ff @(posedge clock) begin
      if (reset) begin
         bg_enable_ff  <= 1'b0;
         spr_enable_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BG_ENABLE:  bg_enable_ff  <= csr_data;
            CSR_SPR_ENABLE: spr_enable_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // result fields from the updated v
   always_comb begin
      result.cur_addr   = v_in;
      result.tmp_addr   = t_in;
      result.dot_count  = dot_in;
      result.tile_fetch = fetch;
      result.name_addr  = NT_BASE | {2'b00, v_in[11:0]};
      result.attr_addr  = ATTR_BASE | {2'b00, v_in[11:10], 4'd0, v_in[9:7], v_in[4:2]};
      result.attr_shift = {v_in[6], v_in[1], 1'b0};
   end

endmodule

[rtl/core/sau_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sau_out - result register
// Holds one result beat and decouples the input side from the receiver.
// ----------------------------------------------------------------------------
module sau_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sau_pkg::result_type result,
   output logic                take,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output sau_pkg::result_type rsp_data
);
   import sau_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // room when empty or the held beat leaves this cycle
   assign take       = ~valid_ff | rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (take && load) begin
         data_ff <= result;
      end
   end

endmodule

[rtl/core/scroll_address_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scroll_address_unit - scroll address registers of a tile display
// Tracks v / t / fine X and the dot position, emits fetch addresses per beat.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one beat per item; tuser carries the item kind, tdata the
//    scanline and write value. One result beat per item on the rsp_ channel.
//  - csr_ channel: register 0 bg_enable, register 1 spr_enable; always ready.
//    Write only while no result is outstanding.
//  - Latency: the result of a beat is on rsp_ the cycle after it is taken.
//  - Throughput: one item per cycle unless rsp_ stalls; the state update and
//    address logic sit between the scroll registers and a single result register.
//  - Reset clears v, t, fine X, dot and cursor, sets the column phase to 7
//    and clears both enables and empties the result register.
//  - A stalled receiver holds the result; req_tready stays high while the
//    result register is empty or being drained, so no beat is lost.
// ----------------------------------------------------------------------------
module scroll_address_unit #(
   parameter int LINE_WIDTH     = sau_pkg::LINE_WIDTH_DEF,
   parameter int NAMETABLE_BASE = sau_pkg::NAMETABLE_BASE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // scanline[8:0], value[23:9]
   input  logic [2:0]  req_tuser,   // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // cur_addr[14:0], tmp_addr[29:15], dot_count[38:30],
                                    // name_addr[52:39], attr_addr[66:53], attr_shift[69:67]
   output logic [0:0]  rsp_tuser,   // tile_fetch[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [0:0]  csr_data
);
   import sau_pkg::*;

   logic       beat;
   logic       take;
   result_type result;
   result_type held;

   assign req_tready = take;
   assign beat       = req_tvalid & take;
   assign csr_ready  = 1'b1;

   sau_state #(
      .LINE_WIDTH     (LINE_WIDTH),
      .NAMETABLE_BASE (NAMETABLE_BASE)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index[0]),
      .csr_data  (csr_data[0]),
      .beat      (beat),
      .action    (req_tuser),
      .scanline  (req_tdata[8:0]),
      .value     (req_tdata[23:9]),
      .result    (result)
   );

   sau_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (req_tvalid),
      .result     (result),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (held)
   );

   // pack the result beat
   assign rsp_tdata = {2'b00, held.attr_shift, held.attr_addr, held.name_addr,
                       held.dot_count, held.tmp_addr, held.cur_addr};
   assign rsp_tuser = held.tile_fetch;

endmodule

[dv/scroll_address_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scroll_address_unit_tb - self-checking bench for the scroll address unit
// A shadow copy of the v / t / fine X / dot / column state predicts every
// result beat; dot ticks run through whole lines with directed writes of v, t
// and fine X around the special dots, under several enable settings, with
// random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module scroll_address_unit_tb;
   import sau_pkg::*;

   localparam int LINE_SPAN = LINE_WIDTH_DEF;
   localparam int NT_BASE   = NAMETABLE_BASE_DEF;

   // item kinds the unit leaves alone
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   localparam int PHASE_ITEMS = 310;

   // --------------------------------------------------------------------------
   // shadow of the scroll state and queue of results still to come
   // --------------------------------------------------------------------------
   class scroll_shadow;
      bit [ADDR_W-1:0] cur_v;
      bit [ADDR_W-1:0] tmp_t;
      bit [FINE_W-1:0] fine_x;
      bit [DOT_W-1:0]  dot;
      bit [3:0]        phase;
      bit [8:0]        cursor;
      bit              bg_on;
      bit              spr_on;
      result_type      pending_results[$];
      int unsigned     errors;
      int unsigned     beats;

      function new();
         cur_v  = '0;
         tmp_t  = '0;
         fine_x = '0;
         dot    = '0;
         phase  = 4'd7;
         cursor = '0;
         bg_on  = 1'b0;
         spr_on = 1'b0;
         errors = 0;
         beats  = 0;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function void set_enable(logic idx, logic val);
         if (idx == CSR_BG_ENABLE) begin
            bg_on = val;
         end else begin
            spr_on = val;
         end
      endfunction

      // coarse X, wraps into the horizontal neighbor table
      function bit [ADDR_W-1:0] step_column(bit [ADDR_W-1:0] a);
         if (a[4:0] == 5'h1F) begin
            return {a[14:11], ~a[10], a[9:5], 5'd0};
         end
         return a + 15'd1;
      endfunction

      // fine Y then coarse Y; row 29 flips the vertical table, row 31 just wraps
      function bit [ADDR_W-1:0] step_row(bit [ADDR_W-1:0] a);
         bit [4:0] row;
         bit       flip;
         if (a[14:12] != 3'd7) begin
            return a + 15'h1000;
         end
         row  = a[9:5];
         flip = 1'b0;
         if (row == COARSE_Y_LAST_ROW) begin
            row  = 5'd0;
            flip = 1'b1;
         end else if (row == COARSE_Y_MAX) begin
            row = 5'd0;
         end else begin
            row = row + 5'd1;
         end
         return {3'd0, a[11] ^ flip, a[10], row, a[4:0]};
      endfunction

      // apply one accepted item and queue the result it produces
      function void note_item(logic [2:0] act, logic [8:0] line, logic [14:0] val);
         result_type r;
         bit         fetch;
         bit         live;
         fetch = 1'b0;
         live  = bg_on | spr_on;
         case (act)
            ACT_TICK: begin
               if (dot == DOT_INC_Y && live && line < LINE_VISIBLE)
                  cur_v = step_row(cur_v);
               if (dot == DOT_HORZ && live && line < LINE_VISIBLE)
                  cur_v = (cur_v & MASK_HORZ_KEEP) | (tmp_t & MASK_HORZ_COPY);
               if (dot == DOT_VERT && live && line == LINE_PRE)
                  cur_v = (cur_v & MASK_VERT_KEEP) | (tmp_t & MASK_VERT_COPY);
               if (dot == DOT_LAST && line == LINE_PRE && bg_on)
                  cur_v = step_row(cur_v);
               if (cursor < LINE_SPAN && bg_on) begin
                  if (phase == 4'd0) begin
                     cur_v = step_column(cur_v);
                     fetch = 1'b1;
                     phase = 4'd7;
                  end else begin
                     phase = (phase - 4'd1) & 4'd7;
                  end
               end
               if (cursor < LINE_SPAN)
                  cursor = cursor + 9'd1;
               dot = (dot == DOT_LAST) ? 9'd0 : dot + 9'd1;
            end
            ACT_LINE: begin
               phase  = (fine_x == 3'd0) ? 4'd7 : 4'd7 - {1'b0, fine_x};
               cursor = '0;
               fetch  = 1'b1;
            end
            ACT_WRITE_V:  cur_v = val;
            ACT_WRITE_T:  tmp_t = val;
            ACT_WRITE_FX: fine_x = val[2:0];
            ACT_CONTROL:  tmp_t[11:10] = val[1:0];
            default: ;
         endcase
         r.cur_addr   = cur_v;
         r.tmp_addr   = tmp_t;
         r.dot_count  = dot;
         r.tile_fetch = fetch;
         r.name_addr  = FETCH_W'(NT_BASE) | {2'b00, cur_v[11:0]};
         r.attr_addr  = ATTR_BASE | {2'b00, cur_v[11:10], 4'd0, cur_v[9:7], cur_v[4:2]};
         r.attr_shift = {cur_v[6], cur_v[1], 1'b0};
         pending_results.push_back(r);
      endfunction

      // compare one result beat with the oldest expectation
      function void check_result(logic [71:0] data, logic [0:0] user);
         result_type got;
         result_type want;
         got.cur_addr   = data[14:0];
         got.tmp_addr   = data[29:15];
         got.dot_count  = data[38:30];
         got.name_addr  = data[52:39];
         got.attr_addr  = data[66:53];
         got.attr_shift = data[69:67];
         got.tile_fetch = user[0];
         beats++;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("beat %0d: result with nothing outstanding", beats);
            return;
         end
         want = pending_results.pop_front();
         if (got.cur_addr !== want.cur_addr || got.tmp_addr !== want.tmp_addr ||
             got.dot_count !== want.dot_count || got.tile_fetch !== want.tile_fetch ||
             got.name_addr !== want.name_addr || got.attr_addr !== want.attr_addr ||
             got.attr_shift !== want.attr_shift) begin
            errors++;
            if (errors <= 10) begin
               $display("beat %0d mismatch: exp v=%h t=%h dot=%0d fetch=%0d nt=%h at=%h sh=%0d",
                        beats, want.cur_addr, want.tmp_addr, want.dot_count,
                        want.tile_fetch, want.name_addr, want.attr_addr, want.attr_shift);
               $display("beat %0d mismatch: got v=%h t=%h dot=%0d fetch=%0d nt=%h at=%h sh=%0d",
                        beats, got.cur_addr, got.tmp_addr, got.dot_count,
                        got.tile_fetch, got.name_addr, got.attr_addr, got.attr_shift);
            end
         end
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // signals and instance
   // --------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [0:0]  csr_data;

   scroll_shadow shadow;

   int unsigned burst_left = 0;
   int unsigned rx_mode    = 0;
   int unsigned rx_span    = 0;
   int          hooked_dot = -1;
   logic [8:0]  cur_line   = '0;

   // enable settings per random phase, {bg, spr}
   logic [1:0] enable_plan [5] = '{2'b11, 2'b10, 2'b01, 2'b00, 2'b11};

   scroll_address_unit #(
      .LINE_WIDTH     (LINE_SPAN),
      .NAMETABLE_BASE (NT_BASE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // receiver: modes of always ready, light stalls and heavy stalls
   always @(posedge clock) begin
      if (rx_span == 0) begin
         rx_mode = $urandom_range(0, 2);
         rx_span = $urandom_range(32, 256);
      end
      rx_span--;
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         shadow.check_result(rsp_tdata, rsp_tuser);
   end

   // --------------------------------------------------------------------------
   // drivers
   // --------------------------------------------------------------------------
   // one input beat; the sender may pause between bursts of random length
   task automatic send_item(input logic [2:0] act, input logic [8:0] line,
                            input logic [14:0] val);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {val, line};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.note_item(act, line, val);
   endtask

   task automatic write_csr(input logic idx, input logic val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow.set_enable(idx, val);
   endtask

   // stop sending and wait until every result is back
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [8:0] special_line();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 45)
         return LINE_PRE;
      if (p < 85)
         return 9'($urandom_range(0, 239));
      return 9'($urandom_range(240, 260));
   endfunction

   // one step of a rendered line: writes hooked to certain dots, rare noise,
   // otherwise a dot tick
   task automatic line_step();
      logic [4:0]  row;
      logic [14:0] val;
      if (shadow.dot != hooked_dot) begin
         hooked_dot = shadow.dot;
         case (shadow.dot)
            9'd0: begin
               cur_line = ($urandom_range(0, 3) == 0) ? LINE_PRE : 9'($urandom_range(0, 261));
               if ($urandom_range(0, 1) == 0)
                  send_item(ACT_WRITE_FX, cur_line, 15'($urandom));
               send_item(ACT_LINE, cur_line, 15'($urandom));
            end
            9'd200: begin
               if ($urandom_range(0, 2) == 0)
                  send_item(ACT_WRITE_T, cur_line, 15'($urandom));
            end
            9'd248: begin
               // prime v so the row step hits its wrap cases
               if ($urandom_range(0, 1) == 0) begin
                  case ($urandom_range(0, 3))
                     0:       row = COARSE_Y_LAST_ROW;
                     1:       row = COARSE_Y_MAX;
                     2:       row = 5'd30;
                     default: row = 5'($urandom);
                  endcase
                  val = 15'($urandom);
                  val[9:5] = row;
                  if ($urandom_range(0, 3) != 0)
                     val[14:12] = 3'd7;
                  send_item(ACT_WRITE_V, cur_line, val);
               end
            end
            9'd300: begin
               if ($urandom_range(0, 1) == 0)
                  send_item(ACT_WRITE_T, cur_line, 15'($urandom));
            end
            default: ;
         endcase
      end
      if ($urandom_range(0, 99) < 6) begin
         send_item(3'($urandom_range(0, 7)), 9'($urandom_range(0, 261)), 15'($urandom));
      end else if (shadow.dot == DOT_INC_Y || shadow.dot == DOT_HORZ ||
                   shadow.dot == DOT_VERT || shadow.dot == DOT_LAST) begin
         send_item(ACT_TICK, special_line(), 15'($urandom));
      end else begin
         send_item(ACT_TICK, cur_line, 15'($urandom));
      end
   endtask

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   initial begin
      int unsigned start_items;
      int unsigned sent;
      shadow = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_TICK;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_BG_ENABLE;
      csr_data   <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: write extremes, every kind, unused kinds, both fine X cases
      send_item(ACT_WRITE_V, 9'd0, 15'h7FFF);
      send_item(ACT_WRITE_T, 9'd0, 15'h0000);
      send_item(ACT_WRITE_T, 9'd261, 15'h7FFF);
      send_item(ACT_CONTROL, 9'd0, 15'h7FFC);
      send_item(ACT_CONTROL, 9'd0, 15'h0003);
      send_item(ACT_WRITE_FX, 9'd0, 15'h7FFF);
      send_item(ACT_LINE, 9'd0, 15'h0000);
      send_item(ACT_SPARE_LO, 9'd261, 15'h7FFF);
      send_item(ACT_SPARE_HI, 9'd256, 15'h5555);
      send_item(ACT_TICK, 9'd0, 15'h0000);
      send_item(ACT_TICK, 9'd261, 15'h7FFF);
      send_item(ACT_TICK, 9'd256, 15'h2AAA);
      send_item(ACT_WRITE_FX, 9'd0, 15'h7FF8);
      send_item(ACT_LINE, 9'd0, 15'h7FFF);
      send_item(ACT_WRITE_V, 9'd0, 15'h0000);
      send_item(ACT_TICK, 9'd239, 15'h0000);
      send_item(ACT_TICK, 9'd240, 15'h0000);
      send_item(ACT_WRITE_FX, 9'd0, 15'h0003);
      send_item(ACT_LINE, 9'd0, 15'h0000);
      send_item(ACT_TICK, 9'd100, 15'h0000);

      // random: rendered lines under each enable setting
      for (int ph = 0; ph < 5; ph++) begin
         settle_idle();
         write_csr(CSR_BG_ENABLE, enable_plan[ph][1]);
         write_csr(CSR_SPR_ENABLE, enable_plan[ph][0]);
         csr_valid <= 1'b0;
         start_items = shadow.beats + shadow.outstanding();
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            line_step();
            sent = shadow.beats + shadow.outstanding() - start_items;
         end
      end

      settle_idle();
      repeat (8) @(posedge clock);
      if (shadow.errors == 0 && shadow.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
